>>> rtl/hat_pkg.sv
// ----------------------------------------------------------------------------
// Habit association table package
// Shared widths, constants and status codes.
// ----------------------------------------------------------------------------
package hat_pkg;

  localparam int unsigned HabitSlotsDef  = 64;
  localparam int unsigned ActionSlotsDef = 64;

  localparam logic [15:0] QOneSat      = 16'hFFFF;
  localparam logic [15:0] InitStrength = 16'd6554;

  localparam logic [6:0]  ActionCountRst = 7'd8;
  localparam logic [15:0] LearnStepRst   = 16'd655;
  localparam logic [15:0] ThresholdRst   = 16'd45875;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StInvalid = 2'd1,
    StFull    = 2'd2,
    StNoMatch = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    KindRegister   = 3'd0,
    KindStrengthen = 3'd1,
    KindCompleted  = 3'd2,
    KindCheck      = 3'd3,
    KindRead       = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    CfgActionCount = 2'd0,
    CfgLearnStep   = 2'd1,
    CfgThreshold   = 2'd2
  } cfg_idx_e;

  // Divider request and response.
  typedef struct packed {
    logic        start;
    logic [31:0] num;
    logic [15:0] den;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quo;
  } div_rsp_t;

endpackage

>>> rtl/hat_divider.sv
// ----------------------------------------------------------------------------
// Habit table divider
// Restoring divider, one quotient bit per cycle, 32 by 16 bits.
// ----------------------------------------------------------------------------
module hat_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hat_pkg::div_req_t req_i,
  output hat_pkg::div_rsp_t rsp_o
);

  logic [31:0] quo_q, quo_d;
  logic [16:0] rem_q, rem_d;
  logic [15:0] den_q, den_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [16:0] shifted;

  always_comb begin
    quo_d   = quo_q;
    rem_d   = rem_q;
    den_d   = den_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    shifted = {rem_q[15:0], quo_q[31]};
    if (req_i.start) begin
      quo_d  = req_i.num;
      rem_d  = '0;
      den_d  = req_i.den;
      cnt_d  = 6'd32;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (shifted >= {1'b0, den_q}) begin
        rem_d = shifted - {1'b0, den_q};
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

  busy_cnt_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q != 6'd0) else $error("divider busy with zero count");
  done_after_busy_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("done without busy");
  start_busy_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |=> busy_q) else $error("start did not set busy");

endmodule

>>> rtl/habit_association_table.sv
// ----------------------------------------------------------------------------
// Habit association table
// Append-only table of habits, context to action, with strength and stats.
// ----------------------------------------------------------------------------
// Usage: an input word (kind, context_req, act_id, habit_index, success)
// is taken when in_valid_i is high and in_stall_o is low. Each word gives
// exactly one result word on out_valid_o, held until out_stall_i is low.
// The table lives in one synchronous memory of HABIT_SLOTS entries with a
// registered read; a sequencer reads, modifies and writes it back.
// A word that is answered at once (bad id, full table, unknown kind, empty
// check, completed without a habit) goes straight to the output state;
// register first writes its entry, read goes through SRead and SScan. Check
// scans one entry per cycle from position 0 up to a match or the last entry.
// Strengthen runs the serial divider for the success mean and writes the
// entry back; completed first scans for the habit of its action and, on a
// hit, does the same.
// One word is in flight at a time; the next input is taken at the earliest
// in the cycle after the result is placed in the output register, so a
// stalled result holds back only the input, never a finished word.
// Reset clears the entry count, the per-action habit flags and restores the
// configuration registers; entry contents are not cleared.
// Configuration is written through cfg_we_i, cfg_idx_i and cfg_data_i; the user
// must write it only while no word is in flight, the block does not enforce this.
// ----------------------------------------------------------------------------
module habit_association_table #(
  parameter int unsigned HABIT_SLOTS  = hat_pkg::HabitSlotsDef,
  parameter int unsigned ACTION_SLOTS = hat_pkg::ActionSlotsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  kind_i,
  input  logic [31:0] context_req_i,
  input  logic [5:0]  act_id_i,
  input  logic [5:0]  habit_index_i,
  input  logic        success_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [5:0]  found_index_o,
  output logic [5:0]  found_action_o,
  output logic [15:0] strength_out_o,
  output logic [15:0] success_mean_o,
  output logic [15:0] repeat_count_o
);

  localparam int unsigned HW = (HABIT_SLOTS > 1) ? $clog2(HABIT_SLOTS) : 1;
  localparam int unsigned CW = $clog2(HABIT_SLOTS + 1);
  localparam int unsigned AW = (ACTION_SLOTS > 1) ? $clog2(ACTION_SLOTS) : 1;
  localparam int unsigned EW = 32 + 6 + 16 + 16 + 16;

  typedef enum logic [3:0] {
    SIdle, SRead, SScan, SDiv, SDivWait, SWrite, SOut
  } state_e;

  typedef struct packed {
    logic [31:0] ctx;
    logic [5:0]  act;
    logic [15:0] str;
    logic [15:0] rep;
    logic [15:0] mean;
  } entry_t;

  // Configuration.
  logic [6:0]  act_cnt_q;
  logic [15:0] step_q, thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_cnt_q <= hat_pkg::ActionCountRst;
      step_q    <= hat_pkg::LearnStepRst;
      thr_q     <= hat_pkg::ThresholdRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        hat_pkg::CfgActionCount: act_cnt_q <= cfg_data_i[6:0];
        hat_pkg::CfgLearnStep:   step_q    <= cfg_data_i;
        hat_pkg::CfgThreshold:   thr_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Entry memory.
  logic [EW-1:0] mem [HABIT_SLOTS];
  logic [HW-1:0] rd_addr, wr_addr;
  logic          wr_en;
  entry_t        wr_data, rd_data;
  logic [EW-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_q <= mem[rd_addr];
  end
  assign rd_data = entry_t'(rd_q);

  logic [ACTION_SLOTS-1:0] habit_flag_q;
  logic [CW-1:0]           total_q;

  state_e        state_q;
  logic [2:0]    kind_q;
  logic [31:0]   ctx_q;
  logic [5:0]    act_q;
  logic          ok_q;
  logic [HW-1:0] idx_q;
  entry_t        ent_q;
  logic [1:0]    st_q;
  logic          show_q;
  logic          out_v_q;
  logic [1:0]    o_st_q;
  logic [5:0]    o_idx_q, o_act_q;
  logic [15:0]   o_str_q, o_mean_q, o_rep_q;

  hat_pkg::div_req_t dreq;
  hat_pkg::div_rsp_t drsp;
  hat_divider u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  logic accept;
  assign in_stall_o = (state_q != SIdle);
  assign accept     = in_valid_i && !in_stall_o;

  logic act_ok;
  assign act_ok = ({1'b0, act_id_i} < act_cnt_q) &&
                  (32'(act_id_i) < ACTION_SLOTS);
  logic hix_ok;
  assign hix_ok = (32'(habit_index_i) < 32'(total_q)) &&
                  (32'(habit_index_i) < HABIT_SLOTS);
  logic last_idx;
  assign last_idx = (32'(idx_q) + 1 >= 32'(total_q));

  // Strengthen arithmetic on the loaded entry.
  logic [15:0] n_new, half_step;
  logic [16:0] str_up;
  logic [31:0] num;
  assign n_new     = (ent_q.rep != hat_pkg::QOneSat) ? ent_q.rep + 16'd1 : ent_q.rep;
  assign num       = 32'(ent_q.mean) * 32'(n_new - 16'd1) + (ok_q ? 32'h10000 : 32'h0);
  assign half_step = {1'b0, step_q[15:1]};
  assign str_up    = {1'b0, ent_q.str} + {1'b0, step_q};

  // The divider takes the numerator and the new count in the SDiv cycle.
  assign dreq.start = (state_q == SDiv);
  assign dreq.num   = num;
  assign dreq.den   = n_new;

  always_comb begin
    rd_addr = idx_q;
    if (state_q == SIdle) rd_addr = HW'(habit_index_i);
    if (state_q == SScan) rd_addr = idx_q + HW'(1);
    wr_en   = (state_q == SWrite);
    wr_addr = idx_q;
    wr_data = ent_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= SIdle;
      habit_flag_q <= '0;
      total_q      <= '0;
      out_v_q      <= 1'b0;
    end else begin
      if (out_v_q && !out_stall_i && state_q != SOut) out_v_q <= 1'b0;
      case (state_q)
        SIdle: begin
          if (accept) begin
            kind_q <= kind_i;
            ctx_q  <= context_req_i;
            act_q  <= act_id_i;
            ok_q   <= success_i;
            show_q <= 1'b0;
            st_q   <= hat_pkg::StOk;
            idx_q  <= HW'(habit_index_i);
            state_q <= SOut;
            case (kind_i)
              hat_pkg::KindRegister: begin
                if (!act_ok) st_q <= hat_pkg::StInvalid;
                else if (32'(total_q) >= HABIT_SLOTS) st_q <= hat_pkg::StFull;
                else begin
                  idx_q  <= HW'(total_q);
                  ent_q  <= '{ctx: context_req_i, act: act_id_i,
                              str: hat_pkg::InitStrength, rep: '0, mean: '0};
                  habit_flag_q[AW'(act_id_i)] <= 1'b1;
                  total_q <= total_q + CW'(1);
                  show_q  <= 1'b1;
                  state_q <= SWrite;
                end
              end
              hat_pkg::KindStrengthen, hat_pkg::KindRead: begin
                if (!hix_ok) st_q <= hat_pkg::StInvalid;
                else state_q <= SRead;
              end
              hat_pkg::KindCompleted: begin
                if (!act_ok) st_q <= hat_pkg::StInvalid;
                else if (habit_flag_q[AW'(act_id_i)] && total_q != '0) begin
                  idx_q   <= '0;
                  state_q <= SRead;
                end
              end
              hat_pkg::KindCheck: begin
                if (total_q == '0) st_q <= hat_pkg::StNoMatch;
                else begin
                  idx_q   <= '0;
                  state_q <= SRead;
                end
              end
              default: st_q <= hat_pkg::StInvalid;
            endcase
          end
        end
        SRead: begin
          // Memory output is valid for idx_q in the next state.
          state_q <= SScan;
        end
        SScan: begin
          ent_q <= rd_data;
          case (kind_q)
            hat_pkg::KindRead: begin
              show_q  <= 1'b1;
              state_q <= SOut;
            end
            hat_pkg::KindStrengthen: state_q <= SDiv;
            hat_pkg::KindCompleted: begin
              if (rd_data.act == act_q) state_q <= SDiv;
              else if (last_idx) state_q <= SOut;
              else idx_q <= idx_q + HW'(1);
            end
            default: begin
              if (rd_data.ctx == ctx_q && rd_data.str > thr_q) begin
                show_q  <= 1'b1;
                state_q <= SOut;
              end else if (last_idx) begin
                st_q    <= hat_pkg::StNoMatch;
                state_q <= SOut;
              end else idx_q <= idx_q + HW'(1);
            end
          endcase
          // The entry sits in ent_q from the next cycle on.
        end
        SDiv: begin
          ent_q.rep <= n_new;
          state_q   <= SDivWait;
        end
        SDivWait: begin
          if (drsp.done) begin
            ent_q.mean <= (drsp.quo > 32'(hat_pkg::QOneSat)) ? hat_pkg::QOneSat
                                                             : drsp.quo[15:0];
            if (ok_q)
              ent_q.str <= str_up[16] ? hat_pkg::QOneSat : str_up[15:0];
            else
              ent_q.str <= (ent_q.str > half_step) ? ent_q.str - half_step : '0;
            show_q  <= 1'b1;
            state_q <= SWrite;
          end
        end
        SWrite: state_q <= SOut;
        SOut: begin
          if (!out_v_q || !out_stall_i) begin
            out_v_q  <= 1'b1;
            o_st_q   <= st_q;
            o_idx_q  <= show_q ? 6'(idx_q) : '0;
            o_act_q  <= show_q ? ent_q.act : '0;
            o_str_q  <= show_q ? ent_q.str : '0;
            o_mean_q <= show_q ? ent_q.mean : '0;
            o_rep_q  <= show_q ? ent_q.rep : '0;
            state_q  <= SIdle;
          end
        end
        default: state_q <= SIdle;
      endcase
    end
  end

  assign out_valid_o    = out_v_q;
  assign status_o       = o_st_q;
  assign found_index_o  = o_idx_q;
  assign found_action_o = o_act_q;
  assign strength_out_o = o_str_q;
  assign success_mean_o = o_mean_q;
  assign repeat_count_o = o_rep_q;

  total_bound_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(total_q) <= HABIT_SLOTS) else $error("entry count overflow");
  one_accept_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q != SIdle) else $error("accepted word not in progress");
  write_then_out_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == SWrite |=> state_q == SOut) else $error("write not followed by output");
  out_hold_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_stall_i |=> out_v_q && $stable(o_st_q))
    else $error("stalled result changed");

endmodule

>>> verif/hat_checker.sv
// ----------------------------------------------------------------------------
// Habit association table checker
// Mirrors the habit table from accepted input words and compares every result
// word field by field with the oldest predicted result.
// ----------------------------------------------------------------------------
module hat_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_stall_o,
  input  logic [2:0]  kind_i,
  input  logic [31:0] context_req_i,
  input  logic [5:0]  act_id_i,
  input  logic [5:0]  habit_index_i,
  input  logic        success_i,
  input  logic        out_valid_o,
  input  logic        out_stall_i,
  input  logic [1:0]  status_o,
  input  logic [5:0]  found_index_o,
  input  logic [5:0]  found_action_o,
  input  logic [15:0] strength_out_o,
  input  logic [15:0] success_mean_o,
  input  logic [15:0] repeat_count_o,
  output int          fail_count,
  output int          pending_count,
  output int          habit_total
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  idx;
    logic [5:0]  action;
    logic [15:0] strength;
    logic [15:0] mean;
    logic [15:0] repeats;
  } habit_result_t;

  logic [6:0]  action_count;
  logic [15:0] learn_step;
  logic [15:0] threshold;

  logic [31:0] hab_context [64];
  logic [5:0]  hab_action  [64];
  logic [15:0] hab_strength[64];
  logic [15:0] hab_repeats [64];
  logic [15:0] hab_mean    [64];
  int          hab_count;
  logic        habit_flag  [64];

  habit_result_t results_due[$];

  function automatic habit_result_t entry_view(hat_pkg::status_e st, int h);
    habit_result_t r;
    r.status   = st;
    r.idx      = h[5:0];
    r.action   = hab_action[h];
    r.strength = hab_strength[h];
    r.mean     = hab_mean[h];
    r.repeats  = hab_repeats[h];
    return r;
  endfunction

  function automatic habit_result_t bare_status(hat_pkg::status_e st);
    habit_result_t r;
    r = '0;
    r.status = st;
    return r;
  endfunction

  function automatic void record_outcome(int h, logic ok);
    logic [16:0] n;
    logic [47:0] num;
    logic [47:0] q;
    logic [16:0] s;
    logic [15:0] d;
    n = {1'b0, hab_repeats[h]};
    if (n < 17'd65535) n = n + 17'd1;
    hab_repeats[h] = n[15:0];
    num = 48'(hab_mean[h]) * 48'(n - 17'd1) + (ok ? 48'd65536 : 48'd0);
    q = num / 48'(n);
    hab_mean[h] = (q > 48'd65535) ? 16'hFFFF : q[15:0];
    if (ok) begin
      s = {1'b0, hab_strength[h]} + {1'b0, learn_step};
      hab_strength[h] = (s > 17'd65535) ? 16'hFFFF : s[15:0];
    end else begin
      d = learn_step >> 1;
      hab_strength[h] = (hab_strength[h] > d) ? hab_strength[h] - d : 16'd0;
    end
  endfunction

  function automatic habit_result_t predict_word(logic [2:0] kind, logic [31:0] ctx,
                                                 logic [5:0] act, logic [5:0] hix,
                                                 logic ok);
    logic act_ok;
    act_ok = {1'b0, act} < action_count;
    case (kind)
      hat_pkg::KindRegister: begin
        if (!act_ok) return bare_status(hat_pkg::StInvalid);
        if (hab_count >= 64) return bare_status(hat_pkg::StFull);
        hab_context[hab_count]  = ctx;
        hab_action[hab_count]   = act;
        hab_strength[hab_count] = hat_pkg::InitStrength;
        hab_repeats[hab_count]  = '0;
        hab_mean[hab_count]     = '0;
        habit_flag[act] = 1'b1;
        hab_count++;
        return entry_view(hat_pkg::StOk, hab_count - 1);
      end
      hat_pkg::KindStrengthen: begin
        if (hix >= hab_count) return bare_status(hat_pkg::StInvalid);
        record_outcome(hix, ok);
        return entry_view(hat_pkg::StOk, hix);
      end
      hat_pkg::KindCompleted: begin
        if (!act_ok) return bare_status(hat_pkg::StInvalid);
        if (habit_flag[act]) begin
          for (int h = 0; h < hab_count; h++) begin
            if (hab_action[h] == act) begin
              record_outcome(h, ok);
              return entry_view(hat_pkg::StOk, h);
            end
          end
        end
        return bare_status(hat_pkg::StOk);
      end
      hat_pkg::KindCheck: begin
        for (int h = 0; h < hab_count; h++) begin
          if (hab_context[h] == ctx && hab_strength[h] > threshold)
            return entry_view(hat_pkg::StOk, h);
        end
        return bare_status(hat_pkg::StNoMatch);
      end
      hat_pkg::KindRead: begin
        if (hix >= hab_count) return bare_status(hat_pkg::StInvalid);
        return entry_view(hat_pkg::StOk, hix);
      end
      default: return bare_status(hat_pkg::StInvalid);
    endcase
  endfunction

  task automatic compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    habit_result_t want;
    if (!rst_ni) begin
      action_count = hat_pkg::ActionCountRst;
      learn_step   = hat_pkg::LearnStepRst;
      threshold    = hat_pkg::ThresholdRst;
      hab_count    = 0;
      foreach (habit_flag[i]) habit_flag[i] = 1'b0;
      results_due.delete();
      fail_count = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          hat_pkg::CfgActionCount: action_count = cfg_data_i[6:0];
          hat_pkg::CfgLearnStep:   learn_step = cfg_data_i;
          hat_pkg::CfgThreshold:   threshold = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_o && !out_stall_i) begin
        if (results_due.size() == 0) begin
          $error("result word with no prediction waiting");
          fail_count++;
        end else begin
          want = results_due.pop_front();
          compare_field("status", 16'(want.status), 16'(status_o));
          compare_field("found_index", 16'(want.idx), 16'(found_index_o));
          compare_field("found_action", 16'(want.action), 16'(found_action_o));
          compare_field("strength_out", want.strength, strength_out_o);
          compare_field("success_mean", want.mean, success_mean_o);
          compare_field("repeat_count", want.repeats, repeat_count_o);
        end
      end
      if (in_valid_i && !in_stall_o)
        results_due.push_back(predict_word(kind_i, context_req_i, act_id_i,
                                           habit_index_i, success_i));
    end
    pending_count = results_due.size();
    habit_total   = hab_count;
  end

endmodule

>>> verif/tb_habit_association_table.sv
// ----------------------------------------------------------------------------
// Habit association table testbench
// Drives directed and random request words with random idling and stalls,
// across several configurations; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_habit_association_table;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 1500000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  kind_i = '0;
  logic [31:0] context_req_i = '0;
  logic [5:0]  act_id_i = '0;
  logic [5:0]  habit_index_i = '0;
  logic        success_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  status_o;
  logic [5:0]  found_index_o;
  logic [5:0]  found_action_o;
  logic [15:0] strength_out_o;
  logic [15:0] success_mean_o;
  logic [15:0] repeat_count_o;
  int          fail_count;
  int          pending_count;
  int          habit_total;
  int          cycle_count = 0;
  logic        quiet = 1'b0;
  logic        hold_off = 1'b0;
  logic [6:0]  cur_actions = hat_pkg::ActionCountRst;
  logic [31:0] ctx_pool[8];

  habit_association_table uut (.*);
  hat_checker checker_i (.*);

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // Receiver stalls: random, none in quiet stretches, solid during a hold-off.
  always @(negedge clk_i) begin
    if (rst_ni) out_stall_i <= hold_off || (!quiet && $urandom_range(99) < 15);
  end

  initial begin
    repeat (200) @(negedge clk_i);
    forever begin
      @(negedge clk_i);
      if (rst_ni && $urandom_range(999) == 0) begin
        hold_off = 1'b1;
        repeat (300) @(negedge clk_i);
        hold_off = 1'b0;
      end
    end
  end

  // Returns at the falling edge after valid drops, so the next word never lands
  // in the same time step as the drop.
  task automatic send_word(logic [2:0] k, logic [31:0] c, logic [5:0] a, logic [5:0] h,
                           logic s);
    while (!quiet && $urandom_range(99) < 15) @(negedge clk_i);
    in_valid_i    <= 1'b1;
    kind_i        <= k;
    context_req_i <= c;
    act_id_i      <= a;
    habit_index_i <= h;
    success_i     <= s;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic drain();
    while (pending_count != 0) @(negedge clk_i);
    repeat (120) @(negedge clk_i);
  endtask

  task automatic write_reg(hat_pkg::cfg_idx_e idx, logic [15:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == hat_pkg::CfgActionCount) cur_actions = val[6:0];
    @(negedge clk_i);
  endtask

  // Mostly well-formed requests on known contexts and registered habits.
  task automatic random_word();
    int r;
    logic [5:0] a;
    logic [5:0] h;
    r = $urandom_range(99);
    a = (cur_actions > 0 && $urandom_range(9) != 0) ?
        6'($urandom_range(cur_actions > 64 ? 63 : cur_actions - 1)) : 6'($urandom);
    h = (habit_total > 0 && $urandom_range(9) != 0) ?
        6'($urandom_range(habit_total - 1)) : 6'($urandom);
    if (r < 5 && habit_total < 64)
      send_word(hat_pkg::KindRegister, ctx_pool[$urandom_range(7)], a, h, 1'($urandom));
    else if (r < 45)
      send_word(hat_pkg::KindStrengthen, $urandom, a, h, $urandom_range(3) != 0);
    else if (r < 65)
      send_word(hat_pkg::KindCompleted, $urandom, a, h, 1'($urandom));
    else if (r < 82)
      send_word(hat_pkg::KindCheck,
                $urandom_range(3) == 0 ? $urandom : ctx_pool[$urandom_range(7)],
                a, h, 1'($urandom));
    else if (r < 96)
      send_word(hat_pkg::KindRead, $urandom, a, h, 1'($urandom));
    else
      send_word(3'($urandom_range(7)), $urandom, 6'($urandom), 6'($urandom), 1'($urandom));
  endtask

  initial begin
    foreach (ctx_pool[i]) ctx_pool[i] = $urandom;
    ctx_pool[0] = '0;
    ctx_pool[1] = '1;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: empty table, invalid ids, unknown kinds, extremes.
    send_word(hat_pkg::KindCheck, '0, '0, '0, 1'b0);
    send_word(hat_pkg::KindStrengthen, '0, '0, '0, 1'b1);
    send_word(hat_pkg::KindRead, '1, '1, '1, 1'b0);
    send_word(hat_pkg::KindRegister, '1, 6'd8, '0, 1'b0);
    send_word(hat_pkg::KindCompleted, '0, 6'd3, '0, 1'b1);
    send_word(3'd5, '0, '0, '0, 1'b0);
    send_word(3'd7, '1, '1, '1, 1'b1);
    send_word(hat_pkg::KindRegister, '1, 6'd7, '0, 1'b0);
    send_word(hat_pkg::KindRegister, '0, 6'd0, '0, 1'b0);
    send_word(hat_pkg::KindRegister, 32'hA5A5_5A5A, 6'd7, '0, 1'b0);
    send_word(hat_pkg::KindCompleted, '0, 6'd7, '0, 1'b0);
    send_word(hat_pkg::KindCompleted, '0, 6'd7, '0, 1'b1);
    send_word(hat_pkg::KindStrengthen, '0, '0, 6'd1, 1'b1);
    send_word(hat_pkg::KindStrengthen, '0, '0, 6'd3, 1'b1);
    send_word(hat_pkg::KindRead, '0, '0, 6'd2, 1'b0);
    send_word(hat_pkg::KindCheck, '1, '0, '0, 1'b0);
    drain();

    // Large step to push strengths to saturation and past the threshold.
    write_reg(hat_pkg::CfgActionCount, 16'd64);
    write_reg(hat_pkg::CfgLearnStep, 16'hFFFF);
    write_reg(hat_pkg::CfgThreshold, 16'd0);
    send_word(hat_pkg::KindStrengthen, '0, '0, 6'd0, 1'b1);
    send_word(hat_pkg::KindStrengthen, '0, '0, 6'd0, 1'b1);
    send_word(hat_pkg::KindCheck, '1, '0, '0, 1'b0);
    send_word(hat_pkg::KindRegister, '0, 6'd63, '0, 1'b1);
    send_word(hat_pkg::KindCompleted, '0, 6'd63, '0, 1'b0);
    drain();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          write_reg(hat_pkg::CfgActionCount, 16'd1);
          write_reg(hat_pkg::CfgLearnStep, 16'd0);
          write_reg(hat_pkg::CfgThreshold, 16'hFFFF);
        end
        1: begin
          write_reg(hat_pkg::CfgActionCount, 16'd64);
          write_reg(hat_pkg::CfgLearnStep, 16'd655);
          write_reg(hat_pkg::CfgThreshold, 16'd6553);
        end
        2: begin
          write_reg(hat_pkg::CfgActionCount, 16'h7F);
          write_reg(hat_pkg::CfgLearnStep, 16'd20000);
          write_reg(hat_pkg::CfgThreshold, 16'd45875);
        end
        3: begin
          write_reg(hat_pkg::CfgActionCount, 16'($urandom_range(1, 64)));
          write_reg(hat_pkg::CfgLearnStep, 16'($urandom));
          write_reg(hat_pkg::CfgThreshold, 16'($urandom));
        end
        4: begin
          write_reg(hat_pkg::CfgActionCount, 16'd0);
          write_reg(hat_pkg::CfgLearnStep, 16'd1);
          write_reg(hat_pkg::CfgThreshold, 16'd6554);
        end
        default: begin
          write_reg(hat_pkg::CfgActionCount, 16'd64);
          write_reg(hat_pkg::CfgLearnStep, 16'd3000);
          write_reg(hat_pkg::CfgThreshold, 16'd30000);
        end
      endcase
      quiet = (phase == 2);
      for (int i = 0; i < 320; i++) random_word();
      quiet = 1'b0;
      drain();
    end

    // Fill the table to the end, then hit the full case.
    while (habit_total < 64)
      send_word(hat_pkg::KindRegister, $urandom, 6'($urandom_range(63)), '0, 1'b0);
    send_word(hat_pkg::KindRegister, '0, 6'd1, '0, 1'b0);
    send_word(hat_pkg::KindCompleted, '0, 6'd63, '0, 1'b1);
    drain();

    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
